@@ design/adrp_pkg.sv @@
// Package with decode constants and the classification struct for the ADRP/ADD resolver.
`timescale 1ns / 1ps

package adrp_pkg;

    // Fixed field widths of the stream beats and decoded fields
    localparam int INSTR_W  = 32;
    localparam int FIELD_AW = 48;
    localparam int REG_W    = 5;
    localparam int OFF_W    = 24;

    // Opcode masks and match values
    localparam logic [INSTR_W-1:0] ADR_CLASS_MASK = 32'h9F00_0000;
    localparam logic [INSTR_W-1:0] ADRP_MATCH     = 32'h9000_0000;
    localparam logic [INSTR_W-1:0] ADR_MATCH      = 32'h1000_0000;
    localparam logic [INSTR_W-1:0] ADD_CLASS_MASK = 32'hFF00_0000;
    localparam logic [INSTR_W-1:0] ADD_MATCH      = 32'h9100_0000;

    // Classification of one instruction word against the target register
    typedef struct packed {
        logic is_target;
        logic is_add;
        logic is_adrp;
        logic is_adr;
        logic last;
    } adrp_class_t;

endpackage

@@ design/adrp_in_if.sv @@
// Instruction stream channel: valid/ready handshake with word, address and run end flag.
`timescale 1ns / 1ps

interface adrp_in_if;
    logic                                valid;
    logic                                ready;
    logic [adrp_pkg::INSTR_W-1:0]        instruction_word;
    logic [adrp_pkg::FIELD_AW-1:0]       instruction_address;
    logic                                last_item;

    modport source (output valid, output instruction_word, output instruction_address,
                    output last_item, input ready);
    modport sink (input valid, input instruction_word, input instruction_address,
                  input last_item, output ready);
endinterface

@@ design/adrp_out_if.sv @@
// Result channel: valid/ready handshake with resolved address and found flag.
`timescale 1ns / 1ps

interface adrp_out_if;
    logic                          valid;
    logic                          ready;
    logic [adrp_pkg::FIELD_AW-1:0] resolved_address;
    logic                          found;

    modport source (output valid, output resolved_address, output found, input ready);
    modport sink (input valid, input resolved_address, input found, output ready);
endinterface

@@ design/adrp_add_address_resolver.sv @@
// Top level of the ADRP/ADD address resolver: config register, decode, queue and resolve.
`timescale 1ns / 1ps

// Scans AArch64 instruction beats for the first address formed into the register held in
// cfg_write_data's register (written when cfg_write_enable is high; the user must do so only
// while the block is idle, which the block does not enforce). One instruction beat is taken
// every cycle while instr.ready is high. A beat passes through the decode front end into a
// two-entry queue, and then through the back end's single page-plus-offset add into the
// result register. The result register stalls independently of the input; instr.ready
// drops only once the queue holds two beats. Exactly one result beat is given per run, on
// the first hit or on the last beat of a run without one.
module adrp_add_address_resolver #(
    parameter int ADDR_WIDTH = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_enable,
    input  logic [adrp_pkg::REG_W-1:0]   cfg_write_data,
    adrp_in_if.sink                      instr,
    adrp_out_if.source                   result
);

    localparam int ENTRY_W = $bits(adrp_pkg::adrp_class_t) + adrp_pkg::OFF_W + 2 * ADDR_WIDTH;

    logic [adrp_pkg::REG_W-1:0] target_reg;
    adrp_pkg::adrp_class_t      front_cls;
    logic [adrp_pkg::OFF_W-1:0] front_off;
    logic [ADDR_WIDTH-1:0]      front_page;
    logic [ADDR_WIDTH-1:0]      front_adr;
    logic [ENTRY_W-1:0]         push_data;
    logic [ENTRY_W-1:0]         pop_data;
    logic                       can_pop;
    logic                       take;
    adrp_pkg::adrp_class_t      back_cls;
    logic [adrp_pkg::OFF_W-1:0] back_off;
    logic [ADDR_WIDTH-1:0]      back_page;
    logic [ADDR_WIDTH-1:0]      back_adr;

    // Hold the target register number
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_write_enable)
        begin
            target_reg <= cfg_write_data;
        end
    end

    adrp_front #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .instruction_word    (instr.instruction_word),
        .instruction_address (instr.instruction_address),
        .last_item           (instr.last_item),
        .target_register     (target_reg),
        .cls                 (front_cls),
        .add_offset          (front_off),
        .page_addr           (front_page),
        .adr_addr            (front_adr)
    );

    assign push_data = {front_cls, front_off, front_page, front_adr};

    adrp_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (instr.valid),
        .push_data (push_data),
        .can_push  (instr.ready),
        .pop       (take),
        .can_pop   (can_pop),
        .pop_data  (pop_data)
    );

    assign {back_cls, back_off, back_page, back_adr} = pop_data;

    adrp_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (can_pop),
        .entry_take  (take),
        .cls         (back_cls),
        .add_offset  (back_off),
        .page_addr   (back_page),
        .adr_addr    (back_adr),
        .result      (result)
    );

endmodule

@@ design/adrp_front.sv @@
// Front end: decodes one instruction word and precomputes its candidate addresses.
`timescale 1ns / 1ps

module adrp_front #(
    parameter int ADDR_WIDTH = 48
) (
    input  logic [adrp_pkg::INSTR_W-1:0]  instruction_word,
    input  logic [adrp_pkg::FIELD_AW-1:0] instruction_address,
    input  logic                          last_item,
    input  logic [adrp_pkg::REG_W-1:0]    target_register,
    output adrp_pkg::adrp_class_t         cls,
    output logic [adrp_pkg::OFF_W-1:0]    add_offset,
    output logic [ADDR_WIDTH-1:0]         page_addr,
    output logic [ADDR_WIDTH-1:0]         adr_addr
);

    logic [ADDR_WIDTH-1:0] addr_aw;
    logic signed [20:0]    imm21;
    logic [ADDR_WIDTH-1:0] imm_aw;
    logic [ADDR_WIDTH-1:0] page_base;

    // Classify the word against the target register
    always_comb
    begin
        cls.is_target = (instruction_word[4:0] == target_register);
        cls.is_add    = ((instruction_word & adrp_pkg::ADD_CLASS_MASK) == adrp_pkg::ADD_MATCH)
                        && (instruction_word[9:5] == target_register);
        cls.is_adrp   = ((instruction_word & adrp_pkg::ADR_CLASS_MASK) == adrp_pkg::ADRP_MATCH);
        cls.is_adr    = ((instruction_word & adrp_pkg::ADR_CLASS_MASK) == adrp_pkg::ADR_MATCH);
        cls.last      = last_item;
    end

    // Pick the ADD immediate, shifted up by 12 when the shift bit is set
    assign add_offset = instruction_word[22] ? {instruction_word[21:10], 12'h000}
                                             : {12'h000, instruction_word[21:10]};

    // Form the PC-relative candidates for ADRP and ADR
    assign addr_aw   = ADDR_WIDTH'(instruction_address);
    assign imm21     = {instruction_word[23:5], instruction_word[30:29]};
    assign imm_aw    = ADDR_WIDTH'(imm21);
    assign page_base = {addr_aw[ADDR_WIDTH-1:12], 12'h000};
    assign page_addr = page_base + (imm_aw << 12);
    assign adr_addr  = addr_aw + imm_aw;

endmodule

@@ design/adrp_queue.sv @@
// Two-entry queue that decouples the decode front end from the resolving back end.
`timescale 1ns / 1ps

module adrp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             can_push,
    input  logic             pop,
    output logic             can_pop,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign can_push = (count_reg != 2'd2);
    assign can_pop  = (count_reg != 2'd0);
    assign do_push  = push && can_push;
    assign do_pop   = pop && can_pop;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/adrp_back.sv @@
// Back end: tracks the pending page and run state and drives the result register.
`timescale 1ns / 1ps

module adrp_back #(
    parameter int ADDR_WIDTH = 48
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       entry_valid,
    output logic                       entry_take,
    input  adrp_pkg::adrp_class_t      cls,
    input  logic [adrp_pkg::OFF_W-1:0] add_offset,
    input  logic [ADDR_WIDTH-1:0]      page_addr,
    input  logic [ADDR_WIDTH-1:0]      adr_addr,
    adrp_out_if.source                 result
);

    logic                  page_pending_reg;
    logic                  page_pending_next;
    logic [ADDR_WIDTH-1:0] pending_page_reg;
    logic [ADDR_WIDTH-1:0] pending_page_next;
    logic                  run_finished_reg;
    logic                  run_finished_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ADDR_WIDTH-1:0] out_addr_reg;
    logic                  out_found_reg;
    logic                  pop;
    logic                  active;
    logic                  hit;
    logic                  emit;
    logic [ADDR_WIDTH-1:0] hit_addr;

    // Take a beat whenever the result register is free or being drained
    assign entry_take = !out_valid_reg || result.ready;
    assign pop        = entry_valid && entry_take;
    assign active     = !run_finished_reg && cls.is_target;

    // Resolve the beat against the pending page
    always_comb
    begin
        hit               = 1'b0;
        hit_addr          = adr_addr;
        page_pending_next = page_pending_reg;
        pending_page_next = pending_page_reg;
        run_finished_next = run_finished_reg;
        if (active)
        begin
            if (page_pending_reg && cls.is_add)
            begin
                hit      = 1'b1;
                hit_addr = pending_page_reg + ADDR_WIDTH'(add_offset);
            end
            else
            begin
                hit = cls.is_adr && !cls.is_adrp;
            end
            page_pending_next = cls.is_adrp && !(page_pending_reg && cls.is_add);
            pending_page_next = page_addr;
        end
        if (hit)
        begin
            run_finished_next = 1'b1;
            page_pending_next = 1'b0;
        end
        // Drop all run state after the last beat
        if (cls.last)
        begin
            run_finished_next = 1'b0;
            page_pending_next = 1'b0;
        end
        emit = hit || (cls.last && !run_finished_reg);
    end

    // Hold the result until the sink takes it
    always_comb
    begin
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_pending_reg <= 1'b0;
            run_finished_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                page_pending_reg <= page_pending_next;
                run_finished_reg <= run_finished_next;
            end
        end
    end

    // Load payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pending_page_reg <= pending_page_next;
        end
        if (pop && emit)
        begin
            out_addr_reg  <= hit ? hit_addr : '0;
            out_found_reg <= hit;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.resolved_address = adrp_pkg::FIELD_AW'(out_addr_reg);
    assign result.found            = out_found_reg;

endmodule

@@ design/adrp_checker.sv @@
// Port-level checks for the resolver, bound to the top level.
`timescale 1ns / 1ps

module adrp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          instr_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [adrp_pkg::FIELD_AW-1:0] result_address,
    input logic                          result_found
);

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_address)
                                          && $stable(result_found))
        else $error("stalled result beat changed");

    // Report zero address on not-found
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_found |-> result_address == '0)
        else $error("not-found result carries an address");

    // Queue drains while the result register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |=> instr_ready)
        else $error("input blocked while result register empty");

endmodule

bind adrp_add_address_resolver adrp_checker u_adrp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .instr_ready    (instr.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_address (result.resolved_address),
    .result_found   (result.found)
);
